// ----- hdl/unordered_list_table_macros.svh -----
// assertion macros used by the checker file
`ifndef UNORDERED_LIST_TABLE_MACROS_SVH
`define UNORDERED_LIST_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ULT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list table check failed");

// implication in the next cycle, checked also through reset
`define ULT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("list table check failed");

`endif

// ----- hdl/ult_pkg.sv -----
// package for the unordered list table: constants, opcodes and memory request type
`default_nettype none
package ult_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ADDR_MAX_W   = 8;
  localparam int DATA_W       = 32;

  localparam logic [1:0] OP_INSERT       = 2'd0;
  localparam logic [1:0] OP_REMOVE_FIRST = 2'd1;
  localparam logic [1:0] OP_REMOVE_ALL   = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [DATA_W-1:0]     wdata;
    logic                  re;
    logic [ADDR_MAX_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ----- hdl/unordered_list_table.sv -----
// top level of the unordered list table
//
//  channel   | handshake                  | fields
//  ----------+----------------------------+-----------------------------------
//  request   | start, busy (taken when    | opcode, value
//            | start && !busy)            |
//  result    | done (one-cycle strobe)    | ok, fill_count, is_empty, is_full
//
// insert, refused request: result strobe in the cycle after the request is taken
// removal: one read per cycle through the single ram read port, then a drain
//   of the last read, busy throughout, then the result strobe
// reset (rst, synchronous) empties the list; entries need no clearing
// the result receiver cannot stall; a new request may be taken while done shows
`default_nettype none
module unordered_list_table #(
  parameter int CAPACITY = ult_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode,
  input  wire logic signed [31:0]          value,
  output logic                             done,
  output logic                             ok,
  output logic [CNT_W-1:0]                 fill_count,
  output logic                             is_empty,
  output logic                             is_full
);

  // request from the sequencer to the entry ram
  ult_pkg::mem_req_t          mem_req;
  logic [ult_pkg::DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]           count;

  // sequencer owns count, pointers and the shared comparator
  ult_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode),
    .value   (value),
    .busy    (busy),
    .done    (done),
    .ok      (ok),
    .count   (count),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // entry ram, read data registered
  ult_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // count is already the post-operation value while done is high
  assign fill_count = count;
  assign is_empty   = (count == '0);
  assign is_full    = (count == CNT_W'(CAPACITY));

endmodule
`default_nettype wire

// ----- hdl/ult_store.sv -----
// entry storage: one write port, one registered read port
`default_nettype none
module ult_store #(
  parameter int CAPACITY = ult_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire ult_pkg::mem_req_t          mem_req,
  output logic [ult_pkg::DATA_W-1:0]      rd_data
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [ult_pkg::DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[ADDR_W-1:0]] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr[ADDR_W-1:0]];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ult_ctrl.sv -----
// sequencer: append, and search-and-compact pass with one shared compare unit
`default_nettype none
module ult_ctrl #(
  parameter int CAPACITY = ult_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [1:0]                  opcode,
  input  wire logic [ult_pkg::DATA_W-1:0]  value,
  output logic                             busy,
  output logic                             done,
  output logic                             ok,
  output logic [CNT_W-1:0]                 count,
  output ult_pkg::mem_req_t                mem_req,
  input  wire logic [ult_pkg::DATA_W-1:0]  rd_data
);

  localparam int AW_MAX = ult_pkg::ADDR_MAX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                     state;
  logic [1:0]                 op_r;
  logic [ult_pkg::DATA_W-1:0] value_r;
  logic [CNT_W-1:0]           rd;
  logic [CNT_W-1:0]           wr;
  logic                       found;
  logic                       rvalid;

  logic is_idle;
  logic full_now;
  logic rd_more;
  logic match;
  logic drop;
  logic ins_write;

  assign is_idle   = (state == S_IDLE);
  assign full_now  = (count == CNT_W'(CAPACITY));
  assign rd_more   = (rd != count);
  // the shared compare unit
  assign match     = (rd_data == value_r);
  assign drop      = rvalid && match && ((op_r == ult_pkg::OP_REMOVE_ALL) || !found);
  assign ins_write = is_idle && start && (opcode == ult_pkg::OP_INSERT) && !full_now;

  assign busy = !is_idle;

  always_comb begin
    mem_req.we    = ins_write || ((state == S_SCAN) && rvalid && !drop);
    mem_req.waddr = is_idle ? AW_MAX'(count) : AW_MAX'(wr);
    mem_req.wdata = is_idle ? value : rd_data;
    mem_req.re    = (state == S_SCAN) && rd_more;
    mem_req.raddr = AW_MAX'(rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      rvalid <= 1'b0;
      found  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= opcode;
            value_r <= value;
            priority if (opcode == ult_pkg::OP_INSERT) begin
              done <= 1'b1;
              ok   <= !full_now;
              if (!full_now) begin
                count <= count + CNT_W'(1);
              end
            end else if (((opcode == ult_pkg::OP_REMOVE_FIRST) ||
                          (opcode == ult_pkg::OP_REMOVE_ALL)) && (count != '0)) begin
              state  <= S_SCAN;
              rd     <= '0;
              wr     <= '0;
              found  <= 1'b0;
              rvalid <= 1'b0;
            end else begin
              done <= 1'b1;
              ok   <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          rvalid <= rd_more;
          if (rd_more) begin
            rd <= rd + CNT_W'(1);
          end
          if (rvalid) begin
            if (drop) begin
              found <= 1'b1;
            end else begin
              wr <= wr + CNT_W'(1);
            end
          end
          if (!rd_more && !rvalid) begin
            count <= wr;
            ok    <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ult_checker.sv -----
// port-level checker for the unordered list table, with its bind
`default_nettype none
`include "unordered_list_table_macros.svh"
module ult_checker #(
  parameter int CAPACITY = ult_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic [CNT_W-1:0] fill_count,
  input wire logic             is_empty,
  input wire logic             is_full
);

  `ULT_ASSERT_NOW(a_empty_flag, done, is_empty == (fill_count == '0))
  `ULT_ASSERT_NOW(a_full_flag, done, is_full == (fill_count == CNT_W'(CAPACITY)))
  `ULT_ASSERT_NOW(a_done_not_busy, done, !busy)
  `ULT_ASSERT_NEXT(a_reset_quiet, rst, !done && !busy)
  // a taken request either answers at once or starts a scan
  `ULT_ASSERT_NEXT(a_take_answered, !rst && start && !busy, done || busy)

endmodule

bind unordered_list_table ult_checker #(
  .CAPACITY (CAPACITY)
) u_ult_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .fill_count (fill_count),
  .is_empty   (is_empty),
  .is_full    (is_full)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for the unordered list table: directed and random requests
`timescale 1ns / 100ps

module tb_top;

  // capacity matches the default build of the block
  localparam int CAP = ult_pkg::CAPACITY_DEF;
  localparam int CNT_W = $clog2(CAP + 1);

  // the block answers opcode 3 with a refusal
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

  // settle time outlasts the longest removal, so this covers any late strobe
  localparam int SETTLE = 2 * CAP + 10;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // one queued request; a pause entry holds the sender until the list is quiet
  typedef struct {
    bit          pause;
    logic [1:0]  op;
    logic [31:0] val;
  } list_req_t;

  // status the block should report for one request
  typedef struct {
    logic             ok;
    logic [CNT_W-1:0] fill;
    logic             empty;
    logic             full;
  } list_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = ult_pkg::OP_INSERT;
  logic signed [31:0] value = '0;

  logic busy;
  logic done;
  logic ok;
  logic [CNT_W-1:0] fill_count;
  logic is_empty;
  logic is_full;

  list_req_t req_q[$];
  list_status_t due_status[$];

  // shadow of the list contents, updated as each request is taken
  logic [31:0] slots[CAP];
  int held = 0;

  int mismatches = 0;
  int unsigned cycles = 0;

  // sender burst shaping, owned by the driver process
  int burst_left = 4;
  int gap_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  unordered_list_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .value      (value),
    .done       (done),
    .ok         (ok),
    .fill_count (fill_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  // apply one request to the shadow list and return the status it should give
  function automatic list_status_t list_apply(logic [1:0] op, logic [31:0] v);
    list_status_t s;
    int hit;
    int wr;
    s.ok = 1'b0;
    case (op)
      ult_pkg::OP_INSERT: begin
        // refused when full, nothing moves
        if (held < CAP) begin
          slots[held] = v;
          held++;
          s.ok = 1'b1;
        end
      end
      ult_pkg::OP_REMOVE_FIRST: begin
        // refused when empty; a miss still counts as success
        if (held != 0) begin
          s.ok = 1'b1;
          hit = -1;
          // whole list is searched, no early exit on a smaller entry
          for (int i = 0; i < held; i++) begin
            if (hit < 0 && slots[i] == v) hit = i;
          end
          if (hit >= 0) begin
            for (int j = hit + 1; j < held; j++) slots[j-1] = slots[j];
            held--;
          end
        end
      end
      ult_pkg::OP_REMOVE_ALL: begin
        if (held != 0) begin
          s.ok = 1'b1;
          wr = 0;
          // compact the survivors toward the front, order kept
          for (int i = 0; i < held; i++) begin
            if (slots[i] != v) begin
              slots[wr] = slots[i];
              wr++;
            end
          end
          held = wr;
        end
      end
      default: ;
    endcase
    s.fill = held[CNT_W-1:0];
    s.empty = (held == 0);
    s.full = (held == CAP);
    return s;
  endfunction

  // one line per mismatch
  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("mismatch on %s: expected %0h, got %0h, cycle %0d", field, want, got, cycles);
  endtask

  task automatic queue_req(logic [1:0] op, logic [31:0] val);
    list_req_t r;
    r.pause = 1'b0;
    r.op = op;
    r.val = val;
    req_q.push_back(r);
  endtask

  task automatic queue_pause();
    list_req_t r;
    r.pause = 1'b1;
    r.op = ult_pkg::OP_INSERT;
    r.val = '0;
    req_q.push_back(r);
  endtask

  // driver: a request is taken at an edge where start is high and busy is low;
  // start stays up across busy cycles and is only re-decided once the request
  // has gone or nothing was offered
  always @(posedge clk) begin : drive
    list_req_t nxt;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) due_status.push_back(list_apply(opcode, value));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0) begin
          if (req_q[0].pause) begin
            // hold off until every outstanding status has come back
            if (due_status.size() == 0) void'(req_q.pop_front());
          end else begin
            nxt = req_q.pop_front();
            opcode <= nxt.op;
            value <= nxt.val;
            go = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              // mostly short bursts and short gaps, now and then a long
              // back-to-back stretch, now and then a gap long enough to
              // land anywhere inside a removal
              burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 6);
              case ($urandom_range(0, 5))
                0, 1: gap_left = 0;
                2, 3, 4: gap_left = $urandom_range(1, 4);
                default: gap_left = $urandom_range(5, 25);
              endcase
            end
          end
        end
        start <= go;
      end
    end
  end

  // monitor: done is a one-cycle strobe, the receiver never stalls
  always @(posedge clk) begin : watch
    list_status_t want;
    if (!rst && done) begin
      if (due_status.size() == 0) begin
        note_mismatch("unrequested result", '0, {31'd0, done});
      end else begin
        want = due_status.pop_front();
        if (ok !== want.ok) note_mismatch("ok", 32'(want.ok), 32'(ok));
        if (fill_count !== want.fill)
          note_mismatch("fill_count", 32'(want.fill), 32'(fill_count));
        if (is_empty !== want.empty)
          note_mismatch("is_empty", 32'(want.empty), 32'(is_empty));
        if (is_full !== want.full)
          note_mismatch("is_full", 32'(want.full), 32'(is_full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] pool[6];
    logic [31:0] recent[$];
    logic [31:0] v;
    logic [1:0] op;
    bit fill_phase;
    bit paused;
    int n;
    int len;
    int r;

    // directed part
    // removals and the unused opcode on an empty list are refused
    queue_req(ult_pkg::OP_REMOVE_FIRST, 32'd7);
    queue_req(ult_pkg::OP_REMOVE_ALL, 32'd7);
    queue_req(OP_UNUSED, 32'd0);
    // field extremes plus duplicates
    queue_req(ult_pkg::OP_INSERT, VAL_MIN);
    queue_req(ult_pkg::OP_INSERT, VAL_MAX);
    queue_req(ult_pkg::OP_INSERT, 32'd0);
    queue_req(ult_pkg::OP_INSERT, 32'hffff_ffff);
    queue_req(ult_pkg::OP_INSERT, 32'd5);
    queue_req(ult_pkg::OP_INSERT, 32'd3);
    queue_req(ult_pkg::OP_INSERT, 32'd5);
    queue_req(ult_pkg::OP_INSERT, 32'd5);
    // miss: success with nothing changed
    queue_req(ult_pkg::OP_REMOVE_FIRST, 32'd12345);
    queue_req(ult_pkg::OP_REMOVE_ALL, 32'hdead_beef);
    // match sits after smaller entries, search must not stop early
    queue_req(ult_pkg::OP_REMOVE_FIRST, 32'd3);
    // only the first of the three fives goes, then the rest at once
    queue_req(ult_pkg::OP_REMOVE_FIRST, 32'd5);
    queue_req(ult_pkg::OP_REMOVE_ALL, 32'd5);
    queue_req(ult_pkg::OP_REMOVE_FIRST, VAL_MIN);
    queue_req(ult_pkg::OP_REMOVE_ALL, VAL_MAX);
    // two left; fill to capacity, then overflow and the unused opcode when full
    for (int i = 0; i < CAP - 2; i++) queue_req(ult_pkg::OP_INSERT, $urandom);
    queue_req(ult_pkg::OP_INSERT, 32'd1);
    queue_req(OP_UNUSED, VAL_MAX);
    queue_req(ult_pkg::OP_REMOVE_FIRST, 32'd0);
    queue_pause();

    // random part: alternating fill-heavy and drain-heavy phases over a small
    // value pool so that matches and duplicates are common
    n = 0;
    fill_phase = 1'b0;
    paused = 1'b0;
    while (n < 450) begin
      fill_phase = !fill_phase;
      len = $urandom_range(15, 50);
      // new pool at the start of each fill phase, drain reuses it
      if (fill_phase) begin
        for (int i = 0; i < 6; i++) begin
          case ($urandom_range(0, 3))
            0: pool[i] = $urandom;
            1: pool[i] = $urandom_range(0, 7) - 4;
            2: pool[i] = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default: pool[i] = $urandom_range(0, 31);
          endcase
        end
      end
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_UNUSED;
        else if (fill_phase)
          op = (r < 78) ? ult_pkg::OP_INSERT :
               (r < 90) ? ult_pkg::OP_REMOVE_FIRST : ult_pkg::OP_REMOVE_ALL;
        else
          op = (r < 30) ? ult_pkg::OP_INSERT :
               (r < 75) ? ult_pkg::OP_REMOVE_FIRST : ult_pkg::OP_REMOVE_ALL;
        // removals in a drain phase also target leftovers from earlier phases
        if (op != ult_pkg::OP_INSERT && !fill_phase && recent.size() != 0 &&
            $urandom_range(0, 1))
          v = recent[$urandom_range(0, recent.size() - 1)];
        else if ($urandom_range(0, 9) < 7)
          v = pool[$urandom_range(0, 5)];
        else
          v = $urandom;
        if (op == ult_pkg::OP_INSERT) begin
          recent.push_back(v);
          if (recent.size() > 32) void'(recent.pop_front());
        end
        queue_req(op, v);
        n++;
      end
      // one mid-run pause with the list drained of outstanding work
      if (!paused && n >= 250) begin
        queue_pause();
        paused = 1'b1;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || start) @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    // watch for stray strobes after the last expected status
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
